/* rtl/core/ola_pkg.sv */
`timescale 1ns / 1ps

package ola_pkg;

  // Default sizing of the list.
  localparam int CAPACITY_DEF   = 256;
  localparam int DATA_WIDTH_DEF = 32;

  // The search logic looks at the cells in groups of this many.
  localparam int GROUP_SIZE = 16;
  localparam int LOCAL_W    = $clog2(GROUP_SIZE);

  // Widths of the stream payload fields.
  localparam int OPCODE_W    = 3;
  localparam int POSITION_W  = 9;
  localparam int VALUE_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int READ_W      = 32;
  localparam int FOUND_W     = 8;
  localparam int LENGTH_W    = 9;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // Operation codes.
  typedef enum logic [OPCODE_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SET    = 3'd4,
    OP_GET    = 3'd5,
    OP_FIND   = 3'd6
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_ILLEGAL  = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_GROUP = 2'd1,
    S_FINAL = 2'd2
  } fsm_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_up;
    logic shift_down;
    logic load;
  } cell_cmd_t;

  // Per-group search answer: first hit and its place within the group.
  typedef struct packed {
    logic               hit;
    logic [LOCAL_W-1:0] idx;
  } grp_hit_t;

endpackage

/* rtl/core/ola_cell.sv */
`timescale 1ns / 1ps

// One list entry. It holds its word, takes its left neighbour's word when the
// tail moves up, its right neighbour's word when the tail moves down, or the
// new value when it is the addressed position.
module ola_cell #(
  parameter int DATA_WIDTH  = ola_pkg::DATA_WIDTH_DEF,
  parameter int INDEX_WIDTH = 8,
  parameter int INDEX       = 0
) (
  input  logic                   clk_i,
  input  ola_pkg::cell_cmd_t     cmd_i,
  input  logic [INDEX_WIDTH-1:0] pos_i,
  input  logic [DATA_WIDTH-1:0]  value_i,
  input  logic [DATA_WIDTH-1:0]  left_i,
  input  logic [DATA_WIDTH-1:0]  right_i,
  output logic [DATA_WIDTH-1:0]  word_o
);

  localparam logic [INDEX_WIDTH-1:0] MyIdx = INDEX_WIDTH'(INDEX);

  logic [DATA_WIDTH-1:0] word_q, word_d;

  // Select the next content of this entry.
  always_comb begin
    word_d = word_q;
    if (cmd_i.shift_up) begin
      if (MyIdx > pos_i) begin
        word_d = left_i;
      end else if (MyIdx == pos_i) begin
        word_d = value_i;
      end
    end else if (cmd_i.shift_down) begin
      if (MyIdx >= pos_i) begin
        word_d = right_i;
      end
    end else if (cmd_i.load) begin
      if (MyIdx == pos_i) begin
        word_d = value_i;
      end
    end
  end

  // Entry storage; its content is meaningless until written.
  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

/* rtl/core/ola_group.sv */
`timescale 1ns / 1ps

// First search stage over one group of cells. It registers the hit and place
// of the first valid match with the key, and the word at the selected place.
module ola_group #(
  parameter int DATA_WIDTH  = ola_pkg::DATA_WIDTH_DEF,
  parameter int COUNT_WIDTH = 9,
  parameter int BASE        = 0
) (
  input  logic                                             clk_i,
  input  logic                                             en_i,
  input  logic [ola_pkg::GROUP_SIZE-1:0][DATA_WIDTH-1:0]   words_i,
  input  logic [DATA_WIDTH-1:0]                            key_i,
  input  logic [ola_pkg::LOCAL_W-1:0]                      sel_i,
  input  logic [COUNT_WIDTH-1:0]                           count_i,
  output ola_pkg::grp_hit_t                                hit_o,
  output logic [DATA_WIDTH-1:0]                            word_o
);

  logic [ola_pkg::GROUP_SIZE-1:0] match;
  ola_pkg::grp_hit_t              hit_d, hit_q;
  logic [DATA_WIDTH-1:0]          word_q;

  // Compare every entry of the group that lies inside the list.
  for (genvar k = 0; k < ola_pkg::GROUP_SIZE; k++) begin : g_cmp
    assign match[k] = (words_i[k] == key_i) && (32'(BASE + k) < 32'(count_i));
  end

  // Lowest matching place wins.
  always_comb begin
    hit_d = '0;
    for (int k = ola_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
      if (match[k]) begin
        hit_d.hit = 1'b1;
        hit_d.idx = ola_pkg::LOCAL_W'(k);
      end
    end
  end

  // Stage register.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hit_q  <= hit_d;
      word_q <= words_i[sel_i];
    end
  end

  assign hit_o  = hit_q;
  assign word_o = word_q;

endmodule

/* rtl/core/ordered_array_list_engine_core.sv */
`timescale 1ns / 1ps

// Ordered list engine: a row of CAPACITY cells holds the list in position
// order, and every cell moves its word to or from its neighbour in the same
// cycle. For clear, append, insert, remove and set (also for a get with an
// illegal position and an unused opcode) the result is registered at the edge
// that accepts the transaction, and the next transaction can be taken in the
// following cycle once the result is taken. get and find instead pass through
// a group stage (16 cells compared or selected per group) and a merge stage
// across the groups before the result register. One operation is in progress
// at a time; the output register lets a new transaction enter while the
// previous result is still being taken. Entries have no reset and need no
// clearing pass after reset; only positions inside the list are ever read.
module ordered_array_list_engine_core #(
  parameter int CAPACITY   = ola_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = ola_pkg::DATA_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [2:0] opcode, [11:3] position, [43:12] value, [47:44] zero
  input  logic [ola_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [1:0] status, [33:2] read_value, [41:34] found_position,
  // [50:42] list_length, [55:51] zero
  output logic [ola_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int IW   = $clog2(CAPACITY);
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int GS   = ola_pkg::GROUP_SIZE;
  localparam int LW   = ola_pkg::LOCAL_W;
  localparam int NG   = (CAPACITY + GS - 1) / GS;
  localparam int PADN = NG * GS;
  localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
  localparam int PW   = LW + GW;
  localparam int MW   = (CW > ola_pkg::POSITION_W) ? CW : ola_pkg::POSITION_W;

  // Input fields.
  ola_pkg::op_e                     in_op;
  logic [ola_pkg::POSITION_W-1:0]   in_pos;
  logic [DATA_WIDTH-1:0]            in_val;
  logic                             s_fire, m_fire;

  assign in_op  = ola_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign in_pos = s_axis_tdata_i[11:3];
  assign in_val = DATA_WIDTH'(s_axis_tdata_i[43:12]);

  // Control and result registers.
  ola_pkg::fsm_e                    state_q, state_d;
  logic [CW-1:0]                    count_q, count_d;
  logic                             out_valid_q;
  ola_pkg::status_e                 status_q;
  logic [ola_pkg::READ_W-1:0]       rd_q;
  logic [ola_pkg::FOUND_W-1:0]      fpos_q;
  logic [ola_pkg::LENGTH_W-1:0]     len_q;
  logic [DATA_WIDTH-1:0]            key_q;
  logic [PW-1:0]                    pos_q;
  logic                             find_q;

  // Decode of the accepted operation.
  ola_pkg::cell_cmd_t               cmd;
  ola_pkg::cell_cmd_t               cell_cmd;
  logic [IW-1:0]                    cmd_pos;
  ola_pkg::status_e                 now_status;
  logic                             go_search;
  logic                             grp_en, fin_load;
  logic                             full;
  logic [MW-1:0]                    pos_ext, cnt_ext;

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire = out_valid_q && m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ola_pkg::S_IDLE) && (!out_valid_q || m_axis_tready_i);

  assign full    = (count_q == CW'(CAPACITY));
  assign pos_ext = MW'(in_pos);
  assign cnt_ext = MW'(count_q);

  // Operation decoder: legality, cell command and new length.
  always_comb begin
    cmd        = '0;
    cmd_pos    = IW'(in_pos);
    count_d    = count_q;
    now_status = ola_pkg::ST_OK;
    go_search  = 1'b0;
    unique case (in_op)
      ola_pkg::OP_CLEAR: begin
        count_d = '0;
      end
      ola_pkg::OP_APPEND: begin
        if (full) begin
          now_status = ola_pkg::ST_FULL;
        end else begin
          cmd.load = 1'b1;
          cmd_pos  = IW'(count_q);
          count_d  = CW'(count_q + 1'b1);
        end
      end
      ola_pkg::OP_INSERT: begin
        if (full) begin
          now_status = ola_pkg::ST_FULL;
        end else if (pos_ext > cnt_ext) begin
          now_status = ola_pkg::ST_ILLEGAL;
        end else begin
          cmd.shift_up = 1'b1;
          count_d      = CW'(count_q + 1'b1);
        end
      end
      ola_pkg::OP_REMOVE: begin
        if (pos_ext >= cnt_ext) begin
          now_status = ola_pkg::ST_ILLEGAL;
        end else begin
          cmd.shift_down = 1'b1;
          count_d        = CW'(count_q - 1'b1);
        end
      end
      ola_pkg::OP_SET: begin
        if (pos_ext >= cnt_ext) begin
          now_status = ola_pkg::ST_ILLEGAL;
        end else begin
          cmd.load = 1'b1;
        end
      end
      ola_pkg::OP_GET: begin
        if (pos_ext >= cnt_ext) begin
          now_status = ola_pkg::ST_ILLEGAL;
        end else begin
          go_search = 1'b1;
        end
      end
      ola_pkg::OP_FIND: begin
        go_search = 1'b1;
      end
      default: begin
        now_status = ola_pkg::ST_OK;
      end
    endcase
  end

  assign cell_cmd = s_fire ? cmd : '0;

  // Chain of cells.
  logic [PADN-1:0][DATA_WIDTH-1:0] words;

  for (genvar i = 0; i < PADN; i++) begin : g_cell
    if (i < CAPACITY) begin : g_live
      logic [DATA_WIDTH-1:0] left_w, right_w;
      if (i == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = words[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = words[i+1];
      end
      ola_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .INDEX_WIDTH(IW),
        .INDEX      (i)
      ) u_cell (
        .clk_i  (clk_i),
        .cmd_i  (cell_cmd),
        .pos_i  (cmd_pos),
        .value_i(in_val),
        .left_i (left_w),
        .right_i(right_w),
        .word_o (words[i])
      );
    end else begin : g_pad
      assign words[i] = '0;
    end
  end

  // Group stage of the search.
  ola_pkg::grp_hit_t       grp_hit  [NG];
  logic [DATA_WIDTH-1:0]   grp_word [NG];

  for (genvar g = 0; g < NG; g++) begin : g_grp
    ola_group #(
      .DATA_WIDTH (DATA_WIDTH),
      .COUNT_WIDTH(CW),
      .BASE       (g * GS)
    ) u_group (
      .clk_i  (clk_i),
      .en_i   (grp_en),
      .words_i(words[g*GS +: GS]),
      .key_i  (key_q),
      .sel_i  (pos_q[LW-1:0]),
      .count_i(count_q),
      .hit_o  (grp_hit[g]),
      .word_o (grp_word[g])
    );
  end

  // Merge stage: first group with a hit, or the group holding the position.
  logic                 any_hit;
  logic [GW-1:0]        hit_grp;
  logic [LW-1:0]        hit_loc;
  logic [GW-1:0]        get_grp;
  logic [DATA_WIDTH-1:0] get_word;

  always_comb begin
    any_hit = 1'b0;
    hit_grp = '0;
    hit_loc = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_hit[g].hit) begin
        any_hit = 1'b1;
        hit_grp = GW'(g);
        hit_loc = grp_hit[g].idx;
      end
    end
  end

  assign get_grp  = pos_q[PW-1:LW];
  assign get_word = grp_word[get_grp];

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ola_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    grp_en   = 1'b0;
    fin_load = 1'b0;
    unique case (state_q)
      ola_pkg::S_IDLE: begin
        if (s_fire && go_search) begin
          state_d = ola_pkg::S_GROUP;
        end
      end
      ola_pkg::S_GROUP: begin
        grp_en  = 1'b1;
        state_d = ola_pkg::S_FINAL;
      end
      ola_pkg::S_FINAL: begin
        fin_load = 1'b1;
        state_d  = ola_pkg::S_IDLE;
      end
      default: begin
        state_d = ola_pkg::S_IDLE;
      end
    endcase
  end

  // List length.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (s_fire) begin
      count_q <= count_d;
    end
  end

  // Search operands held for the duration of a get or find.
  always_ff @(posedge clk_i) begin
    if (s_fire && go_search) begin
      key_q  <= in_val;
      pos_q  <= PW'(in_pos);
      find_q <= (in_op == ola_pkg::OP_FIND);
    end
  end

  // Output register: valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((s_fire && !go_search) || fin_load) begin
      out_valid_q <= 1'b1;
    end else if (m_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register: payload.
  always_ff @(posedge clk_i) begin
    if (s_fire && !go_search) begin
      status_q <= now_status;
      rd_q     <= '0;
      fpos_q   <= '0;
      len_q    <= ola_pkg::LENGTH_W'(count_d);
    end else if (fin_load) begin
      len_q <= ola_pkg::LENGTH_W'(count_q);
      if (find_q) begin
        rd_q <= '0;
        if (any_hit) begin
          status_q <= ola_pkg::ST_OK;
          fpos_q   <= ola_pkg::FOUND_W'({hit_grp, hit_loc});
        end else begin
          status_q <= ola_pkg::ST_NOTFOUND;
          fpos_q   <= '0;
        end
      end else begin
        status_q <= ola_pkg::ST_OK;
        rd_q     <= ola_pkg::READ_W'(get_word);
        fpos_q   <= '0;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b0, len_q, fpos_q, rd_q, status_q};

endmodule

/* rtl/core/ola_core_chk.sv */
`timescale 1ns / 1ps

// Port-level checks for the list engine.
module ola_core_chk #(
  parameter int CAPACITY = ola_pkg::CAPACITY_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [ola_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [ola_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic       s_fire;
  logic [2:0] s_op;

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign s_op   = s_axis_tdata_i[2:0];

  // No result is offered while reset is applied.
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid_o)
    else $error("result offered during reset");

  // A stalled result holds its transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

  // The reported length never exceeds the capacity.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (32'(m_axis_tdata_o[50:42]) <= 32'(CAPACITY)))
    else $error("list length above capacity");

  // A full status is only given when the list is at capacity.
  a_full_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] == 2'(ola_pkg::ST_FULL))
    |-> (m_axis_tdata_o[50:42] == 9'(CAPACITY)))
    else $error("full status with list below capacity");

  // A legal get or find passes the search stages, so no result follows at once.
  a_search_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && ((s_op == 3'(ola_pkg::OP_GET)) || (s_op == 3'(ola_pkg::OP_FIND)))
    |=> !m_axis_tvalid_o || (m_axis_tdata_o[1:0] == 2'(ola_pkg::ST_ILLEGAL)))
    else $error("search result appeared too early");

endmodule

bind ordered_array_list_engine_core ola_core_chk #(.CAPACITY(CAPACITY)) u_ola_core_chk (.*);

/* dv/ordered_array_list_engine_core_tb.sv */
`timescale 1ns / 1ps

module ordered_array_list_engine_core_tb;
  import ola_pkg::*;

  localparam int LIST_CAP       = ola_pkg::CAPACITY_DEF;
  localparam int DIR_ROWS       = 25;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int WATCHDOG_LIMIT = 2000;

  // Opcode that the block leaves unused.
  localparam logic [OPCODE_W-1:0] OP_UNUSED = 3'd7;

  // Kinds of random traffic.
  localparam int MODE_MIXED  = 0;
  localparam int MODE_GROW   = 1;
  localparam int MODE_SHRINK = 2;
  localparam int MODE_TOP    = 3;

  // One expected answer of the list engine.
  typedef struct packed {
    status_e              status;
    logic [READ_W-1:0]    read_value;
    logic [FOUND_W-1:0]   found_pos;
    logic [LENGTH_W-1:0]  length;
  } list_result_t;

  // One row of the directed stimulus; chk marks a hand-written answer.
  typedef struct packed {
    logic [OPCODE_W-1:0]   op;
    logic [POSITION_W-1:0] pos;
    logic [VALUE_W-1:0]    val;
    logic                  chk;
    list_result_t          want;
  } dir_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  // [2:0] opcode, [11:3] position, [43:12] value, [47:44] zero
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  // [1:0] status, [33:2] read_value, [41:34] found_position,
  // [50:42] list_length, [55:51] zero
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  // Shadow copy of the list held by the predictor.
  logic [VALUE_W-1:0] list_mem [LIST_CAP];
  int                 list_len;

  list_result_t expected_results [$];
  int           err_cnt;
  int           in_acc_cnt;
  int           idle_cycles;
  int           items_sent;
  bit           no_gap_stretch;

  // Item currently offered to the block, with its hand-written answer.
  logic         cur_chk;
  list_result_t cur_want;

  ordered_array_list_engine_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  // Directed rows, starting from an empty list.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{OP_GET,    9'd0,   32'h0,        1'b1, '{ST_ILLEGAL,  32'h0, 8'd0, 9'd0}},
    '{OP_REMOVE, 9'd0,   32'h0,        1'b1, '{ST_ILLEGAL,  32'h0, 8'd0, 9'd0}},
    '{OP_SET,    9'd0,   32'h1,        1'b1, '{ST_ILLEGAL,  32'h0, 8'd0, 9'd0}},
    '{OP_FIND,   9'd0,   32'h0,        1'b1, '{ST_NOTFOUND, 32'h0, 8'd0, 9'd0}},
    '{OP_INSERT, 9'd1,   32'h7,        1'b1, '{ST_ILLEGAL,  32'h0, 8'd0, 9'd0}},
    '{OP_INSERT, 9'd511, 32'h7,        1'b1, '{ST_ILLEGAL,  32'h0, 8'd0, 9'd0}},
    '{OP_APPEND, 9'd0,   32'hFFFFFFFF, 1'b1, '{ST_OK,       32'h0, 8'd0, 9'd1}},
    '{OP_INSERT, 9'd0,   32'h0,        1'b1, '{ST_OK,       32'h0, 8'd0, 9'd2}},
    '{OP_INSERT, 9'd2,   32'hA5A5A5A5, 1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_INSERT, 9'd1,   32'h5A5A5A5A, 1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_GET,    9'd0,   32'h0,        1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_GET,    9'd3,   32'h0,        1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_GET,    9'd4,   32'h0,        1'b1, '{ST_ILLEGAL,  32'h0, 8'd0, 9'd4}},
    '{OP_FIND,   9'd0,   32'hFFFFFFFF, 1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_FIND,   9'd0,   32'h12345678, 1'b1, '{ST_NOTFOUND, 32'h0, 8'd0, 9'd4}},
    '{OP_SET,    9'd3,   32'h0,        1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_FIND,   9'd0,   32'h0,        1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_REMOVE, 9'd0,   32'h0,        1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_REMOVE, 9'd2,   32'h0,        1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_REMOVE, 9'd256, 32'h0,        1'b1, '{ST_ILLEGAL,  32'h0, 8'd0, 9'd2}},
    '{OP_UNUSED, 9'd511, 32'hFFFFFFFF, 1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_GET,    9'd1,   32'h0,        1'b0, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_CLEAR,  9'd0,   32'h0,        1'b1, '{ST_OK,       32'h0, 8'd0, 9'd0}},
    '{OP_FIND,   9'd0,   32'hFFFFFFFF, 1'b1, '{ST_NOTFOUND, 32'h0, 8'd0, 9'd0}},
    '{OP_APPEND, 9'd511, 32'h0,        1'b1, '{ST_OK,       32'h0, 8'd0, 9'd1}}
  };

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Prints one line per wrong field and keeps the count.
  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("MISMATCH at %0t: %s, expected 0x%0h, got 0x%0h", $realtime, what, want, got);
    err_cnt++;
  endtask

  // Applies one operation to the shadow list and works out its answer.
  task automatic apply_list_op(input logic [OPCODE_W-1:0] op,
                               input logic [POSITION_W-1:0] pos,
                               input logic [VALUE_W-1:0] val,
                               output list_result_t res);
    int p;
    p   = int'(pos);
    res = '{ST_OK, '0, '0, '0};
    case (op)
      OP_CLEAR: begin
        list_len = 0;
      end
      OP_APPEND: begin
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          list_mem[list_len] = val;
          list_len++;
        end
      end
      OP_INSERT: begin
        // Fullness is tested before the position.
        if (list_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (p > list_len) begin
          res.status = ST_ILLEGAL;
        end else begin
          for (int i = list_len; i > p; i--) list_mem[i] = list_mem[i-1];
          list_mem[p] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (p >= list_len) begin
          res.status = ST_ILLEGAL;
        end else begin
          for (int i = p; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      OP_SET: begin
        if (p >= list_len) res.status = ST_ILLEGAL;
        else list_mem[p] = val;
      end
      OP_GET: begin
        if (p >= list_len) res.status = ST_ILLEGAL;
        else res.read_value = list_mem[p];
      end
      OP_FIND: begin
        // Only valid entries take part; the first match wins.
        res.status = ST_NOTFOUND;
        for (int i = 0; i < list_len; i++) begin
          if (list_mem[i] == val) begin
            res.status    = ST_OK;
            res.found_pos = i[FOUND_W-1:0];
            break;
          end
        end
      end
      default: begin
      end
    endcase
    res.length = list_len[LENGTH_W-1:0];
  endtask

  // Idle length between transactions: mostly short, now and then long.
  function automatic int gap_cycles(input bit honour_stretch);
    int r;
    if (honour_stretch && no_gap_stretch) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // A data word; a small pool makes duplicate entries likely.
  function automatic logic [VALUE_W-1:0] data_word();
    if ($urandom_range(0, 9) < 3) return VALUE_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  // A search key, mostly taken from the live list so that finds hit.
  function automatic logic [VALUE_W-1:0] search_key();
    int r;
    r = $urandom_range(0, 9);
    if (list_len > 0 && r < 6) return list_mem[$urandom_range(0, list_len - 1)];
    if (r < 8) return VALUE_W'($urandom_range(0, 7));
    return $urandom;
  endfunction

  // A position, mostly legal for the operation, sometimes on or past the edge.
  function automatic logic [POSITION_W-1:0] pick_pos(input bit incl_len);
    int top;
    int r;
    r   = $urandom_range(0, 99);
    top = incl_len ? list_len : list_len - 1;
    if (r < 5) return POSITION_W'(list_len + (incl_len ? 1 : 0));
    if (r < 8) return POSITION_W'(list_len);
    if (top < 0) return '0;
    return POSITION_W'($urandom_range(0, top));
  endfunction

  // Builds one random operation of the given kind.
  task automatic make_item(input int mode, output logic [OPCODE_W-1:0] op,
                           output logic [POSITION_W-1:0] pos,
                           output logic [VALUE_W-1:0] val);
    int r;
    r   = $urandom_range(0, 99);
    pos = POSITION_W'($urandom_range(0, 511));
    val = data_word();
    if (mode != MODE_TOP && r < 8) begin
      // Noise: any opcode, any position.
      op  = OPCODE_W'($urandom_range(0, 7));
      val = $urandom;
      return;
    end
    r = $urandom_range(0, 99);
    case (mode)
      MODE_GROW:   op = (r < 45) ? OP_APPEND : (r < 80) ? OP_INSERT :
                        (r < 90) ? OP_GET : OP_FIND;
      MODE_SHRINK: op = (r < 70) ? OP_REMOVE : (r < 85) ? OP_GET : OP_FIND;
      MODE_TOP:    op = OPCODE_W'($urandom_range(OP_APPEND, OP_FIND));
      default:     op = (r < 2)  ? OP_CLEAR  : (r < 17) ? OP_APPEND :
                        (r < 32) ? OP_INSERT : (r < 44) ? OP_REMOVE :
                        (r < 56) ? OP_SET    : (r < 78) ? OP_GET : OP_FIND;
    endcase
    if (mode == MODE_TOP) begin
      // Positions around the upper end of a full or nearly full list.
      case ($urandom_range(0, 5))
        0:       pos = POSITION_W'((list_len > 0) ? list_len - 1 : 0);
        1:       pos = POSITION_W'(list_len);
        2:       pos = POSITION_W'(list_len + 1);
        3:       pos = 9'd255;
        4:       pos = 9'd256;
        default: pos = POSITION_W'($urandom_range(0, 511));
      endcase
    end else begin
      pos = pick_pos(op == OP_INSERT);
    end
    if (op == OP_FIND) val = search_key();
  endtask

  // Offers one item; returns at a falling edge after it is taken and any gap.
  task automatic send_op(input logic [OPCODE_W-1:0] op,
                         input logic [POSITION_W-1:0] pos,
                         input logic [VALUE_W-1:0] val, input logic chk,
                         input list_result_t want);
    int cnt0;
    int gap;
    cnt0            = in_acc_cnt;
    cur_chk         = chk;
    cur_want        = want;
    s_axis_tdata_i  <= {4'b0, val, pos, op};
    s_axis_tvalid_i <= 1'b1;
    do @(negedge clk_i); while (in_acc_cnt == cnt0);
    gap = gap_cycles(1'b1);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic send_random(input int mode);
    logic [OPCODE_W-1:0]   op;
    logic [POSITION_W-1:0] pos;
    logic [VALUE_W-1:0]    val;
    make_item(mode, op, pos, val);
    send_op(op, pos, val, 1'b0, '{ST_OK, '0, '0, '0});
    items_sent++;
  endtask

  // Fills the list to capacity and works the full-list corner cases.
  task automatic fill_and_probe();
    no_gap_stretch = ($urandom_range(0, 1) == 0);
    while (list_len < LIST_CAP) begin
      send_op(OP_APPEND, POSITION_W'($urandom_range(0, 511)), data_word(), 1'b0,
              '{ST_OK, '0, '0, '0});
      items_sent++;
    end
    repeat (40) send_random(MODE_TOP);
  endtask

  // Result checking, prediction on input transactions, and the watchdog.
  always @(posedge clk_i) begin : result_monitor
    list_result_t got;
    list_result_t want;
    list_result_t pred;
    bit           moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        moved          = 1'b1;
        got.status     = status_e'(m_axis_tdata_o[1:0]);
        got.read_value = m_axis_tdata_o[33:2];
        got.found_pos  = m_axis_tdata_o[41:34];
        got.length     = m_axis_tdata_o[50:42];
        if (expected_results.size() == 0) begin
          report_mismatch("result with nothing outstanding", '0, 64'(got));
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status)
            report_mismatch("status", 64'(want.status), 64'(got.status));
          if (got.read_value != want.read_value)
            report_mismatch("read_value", 64'(want.read_value), 64'(got.read_value));
          if (got.found_pos != want.found_pos)
            report_mismatch("found_position", 64'(want.found_pos), 64'(got.found_pos));
          if (got.length != want.length)
            report_mismatch("list_length", 64'(want.length), 64'(got.length));
          if (m_axis_tdata_o[55:51] != '0)
            report_mismatch("padding bits", '0, 64'(m_axis_tdata_o[55:51]));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        moved = 1'b1;
        apply_list_op(s_axis_tdata_i[2:0], s_axis_tdata_i[11:3], s_axis_tdata_i[43:12], pred);
        expected_results.push_back(cur_chk ? cur_want : pred);
        in_acc_cnt++;
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Result side back-pressure: runs of ready with stalls of random length.
  initial begin : ready_driver
    int hi;
    int lo;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      m_axis_tready_i <= 1'b1;
      hi = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
      repeat (hi) @(negedge clk_i);
      lo = gap_cycles(1'b0);
      if (lo > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (lo) @(negedge clk_i);
      end
    end
  end

  // Stimulus: reset, directed table, then phases of random traffic.
  initial begin : stimulus
    bit fill_a;
    bit fill_b;
    int phase;
    int n;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    cur_chk         = 1'b0;
    cur_want        = '{ST_OK, '0, '0, '0};
    list_len        = 0;
    err_cnt         = 0;
    in_acc_cnt      = 0;
    idle_cycles     = 0;
    items_sent      = 0;
    no_gap_stretch  = 1'b0;
    fill_a          = 1'b0;
    fill_b          = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    for (int k = 0; k < DIR_ROWS; k++) begin
      send_op(dir_tab[k].op, dir_tab[k].pos, dir_tab[k].val, dir_tab[k].chk, dir_tab[k].want);
    end

    while (items_sent < RANDOM_ITEMS) begin
      if (!fill_a && items_sent >= 300) begin
        fill_a = 1'b1;
        fill_and_probe();
      end else if (!fill_b && items_sent >= 1000) begin
        fill_b = 1'b1;
        fill_and_probe();
      end else begin
        no_gap_stretch = ($urandom_range(0, 3) == 0);
        phase          = $urandom_range(0, 9);
        n              = $urandom_range(30, 100);
        if (phase < 6) repeat (n) send_random(MODE_MIXED);
        else if (phase < 8) repeat (n) send_random(MODE_GROW);
        else repeat (n) send_random(MODE_SHRINK);
      end
    end

    // Drain the outstanding results, then allow for the pipeline depth.
    s_axis_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", '0, 64'(expected_results.size()));
    if (err_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/ola_pkg.sv
rtl/core/ola_cell.sv
rtl/core/ola_group.sv
rtl/core/ordered_array_list_engine_core.sv
rtl/core/ola_core_chk.sv
dv/ordered_array_list_engine_core_tb.sv
